FILE: design/tapq_pkg.sv
// Shared types and codes for the task admission priority queue.
package tapq_pkg;

    localparam int unsigned RUN_WIDTH      = 8;
    localparam int unsigned LIMIT_WIDTH    = 5;
    localparam int unsigned CFG_DATA_WIDTH = 8;
    localparam int unsigned STATUS_WIDTH   = 2;

    localparam logic [RUN_WIDTH-1:0]   MAX_RUNNING_RST = RUN_WIDTH'(4);
    localparam logic [LIMIT_WIDTH-1:0] QUEUE_LIMIT_RST = LIMIT_WIDTH'(16);

    localparam int unsigned QUEUE_DEPTH_DEF = 16;
    localparam int unsigned TAG_WIDTH_DEF   = 16;
    localparam int unsigned PRIO_WIDTH_DEF  = 8;

    localparam logic CMD_SUBMIT = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [0:0] REG_MAX_RUNNING = 1'b0;
    localparam logic [0:0] REG_QUEUE_LIMIT = 1'b1;

    localparam logic [STATUS_WIDTH-1:0] ST_STARTED  = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_QUEUED   = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_DROPPED  = 2'd2;
    localparam logic [STATUS_WIDTH-1:0] ST_FINISHED = 2'd3;

    // Operation broadcast to every cell of the wait queue
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP,
        CELL_REINSERT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
    } t_cell_ctrl;

endpackage

FILE: design/tapq_cell.sv
// One slot of the sorted wait queue: holds a tag and priority, trades with its neighbours.
module tapq_cell
    import tapq_pkg::*;
#(
    parameter int unsigned TAG_WIDTH  = TAG_WIDTH_DEF,
    parameter int unsigned PRIO_WIDTH = PRIO_WIDTH_DEF,
    parameter int unsigned CNT_WIDTH  = 5,
    parameter int unsigned CELL_IDX   = 0
) (
    input  logic                  i_clk,
    input  t_cell_ctrl            i_ctrl,
    input  logic [TAG_WIDTH-1:0]  i_key_tag,
    input  logic [PRIO_WIDTH-1:0] i_key_prio,
    input  logic [CNT_WIDTH-1:0]  i_count,
    input  logic                  i_left_le,
    input  logic [TAG_WIDTH-1:0]  i_left_tag,
    input  logic [PRIO_WIDTH-1:0] i_left_prio,
    input  logic                  i_right_le,
    input  logic [TAG_WIDTH-1:0]  i_right_tag,
    input  logic [PRIO_WIDTH-1:0] i_right_prio,
    output logic                  o_le,
    output logic [TAG_WIDTH-1:0]  o_tag,
    output logic [PRIO_WIDTH-1:0] o_prio
);

    logic [TAG_WIDTH-1:0]  r_tag;
    logic [PRIO_WIDTH-1:0] r_prio;
    logic [TAG_WIDTH-1:0]  n_tag;
    logic [PRIO_WIDTH-1:0] n_prio;
    logic                  w_occ;

    assign w_occ = CNT_WIDTH'(CELL_IDX) < i_count;
    // occupied and ordered at or before the key: the key goes behind this slot
    assign o_le   = w_occ && (r_prio <= i_key_prio);
    assign o_tag  = r_tag;
    assign o_prio = r_prio;

    always_comb begin
        n_tag  = r_tag;
        n_prio = r_prio;
        case (i_ctrl.op)
            CELL_INSERT: begin
                if (!o_le) begin
                    if (i_left_le) begin
                        n_tag  = i_key_tag;
                        n_prio = i_key_prio;
                    end else begin
                        n_tag  = i_left_tag;
                        n_prio = i_left_prio;
                    end
                end
            end
            CELL_POP: begin
                n_tag  = i_right_tag;
                n_prio = i_right_prio;
            end
            CELL_REINSERT: begin
                // head leaves and re-enters behind its equals in one go
                if (i_right_le) begin
                    n_tag  = i_right_tag;
                    n_prio = i_right_prio;
                end else if (o_le) begin
                    n_tag  = i_key_tag;
                    n_prio = i_key_prio;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_tag  <= n_tag;
        r_prio <= n_prio;
    end

endmodule

FILE: design/task_admission_priority_queue_unit.sv
// Top level: admission control, running count and the chain of queue cells.
//
// Task admission dispatcher. Items arrive on the input channel
// (i_in_valid / o_in_ready) carrying a command, a task tag and a priority:
// a submit starts the task while fewer than max_running run, else queues it
// in priority order (smallest first, stable), else drops it when the queue
// is at its limit. A finish lowers the running count and re-offers the
// queue head, which starts or goes straight back in behind its equals.
// Each item gives one result on the output channel (o_out_valid /
// i_out_ready), registered: it appears the cycle after the item is taken.
// One item is taken per cycle while the receiver keeps up; every queue cell
// shifts, inserts or holds in the same cycle, so no insert or pop walks the chain.
// While a result waits, a new item is taken only in the cycle that result
// leaves, so a stalled receiver holds the block with one result pending.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) apply at once.
// Synchronous active-low reset empties the queue, zeroes the running count
// and loads max_running 4 and queue_limit 16; no clearing pass is needed.
module task_admission_priority_queue_unit
    import tapq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int unsigned TAG_WIDTH   = TAG_WIDTH_DEF,
    parameter int unsigned PRIO_WIDTH  = PRIO_WIDTH_DEF,
    localparam int unsigned CNT_WIDTH  = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [0:0]                i_cfg_idx,
    input  logic [CFG_DATA_WIDTH-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_cmd,
    input  logic [TAG_WIDTH-1:0]      i_task_tag,
    input  logic [PRIO_WIDTH-1:0]     i_priority_req,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [STATUS_WIDTH-1:0]   o_status,
    output logic                      o_launch_valid,
    output logic [TAG_WIDTH-1:0]      o_launch_tag,
    output logic [RUN_WIDTH-1:0]      o_running_count,
    output logic [CNT_WIDTH-1:0]      o_queue_length
);

    logic [RUN_WIDTH-1:0]   r_max_running;
    logic [LIMIT_WIDTH-1:0] r_queue_limit;
    logic [RUN_WIDTH-1:0]   r_running;
    logic [RUN_WIDTH-1:0]   n_running;
    logic [CNT_WIDTH-1:0]   r_count;
    logic [CNT_WIDTH-1:0]   n_count;
    logic                   r_out_valid;

    logic [STATUS_WIDTH-1:0] r_status, n_status;
    logic                    r_launch_valid, n_launch_valid;
    logic [TAG_WIDTH-1:0]    r_launch_tag, n_launch_tag;

    logic                   w_accept;
    logic [RUN_WIDTH-1:0]   w_run_dec;
    logic                   w_room;
    t_cell_ctrl             w_ctrl;
    logic [TAG_WIDTH-1:0]   w_key_tag;
    logic [PRIO_WIDTH-1:0]  w_key_prio;

    logic                   w_le   [QUEUE_DEPTH];
    logic [TAG_WIDTH-1:0]   w_tag  [QUEUE_DEPTH];
    logic [PRIO_WIDTH-1:0]  w_prio [QUEUE_DEPTH];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_run_dec  = (r_running != '0) ? r_running - RUN_WIDTH'(1) : '0;

    // limit above the depth acts as the depth
    assign w_room = (r_count < CNT_WIDTH'(QUEUE_DEPTH)) &&
        ((CNT_WIDTH + LIMIT_WIDTH)'(r_count) < (CNT_WIDTH + LIMIT_WIDTH)'(r_queue_limit));

    assign w_key_tag  = (i_cmd == CMD_SUBMIT) ? i_task_tag     : w_tag[0];
    assign w_key_prio = (i_cmd == CMD_SUBMIT) ? i_priority_req : w_prio[0];

    always_comb begin
        w_ctrl.op      = CELL_HOLD;
        n_running      = r_running;
        n_count        = r_count;
        n_status       = ST_FINISHED;
        n_launch_valid = 1'b0;
        n_launch_tag   = '0;
        if (i_cmd == CMD_SUBMIT) begin
            if (r_running < r_max_running) begin
                n_running      = r_running + RUN_WIDTH'(1);
                n_status       = ST_STARTED;
                n_launch_valid = 1'b1;
                n_launch_tag   = i_task_tag;
            end else if (w_room) begin
                w_ctrl.op = CELL_INSERT;
                n_count   = r_count + CNT_WIDTH'(1);
                n_status  = ST_QUEUED;
            end else begin
                n_status = ST_DROPPED;
            end
        end else begin
            n_running = w_run_dec;
            if (r_count != '0) begin
                if (w_run_dec < r_max_running) begin
                    w_ctrl.op      = CELL_POP;
                    n_count        = r_count - CNT_WIDTH'(1);
                    n_running      = w_run_dec + RUN_WIDTH'(1);
                    n_launch_valid = 1'b1;
                    n_launch_tag   = w_tag[0];
                end else begin
                    w_ctrl.op = CELL_REINSERT;
                end
            end
        end
        if (!w_accept) begin
            w_ctrl.op = CELL_HOLD;
        end
    end

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic                  w_l_le;
            logic [TAG_WIDTH-1:0]  w_l_tag;
            logic [PRIO_WIDTH-1:0] w_l_prio;
            logic                  w_r_le;
            logic [TAG_WIDTH-1:0]  w_r_tag;
            logic [PRIO_WIDTH-1:0] w_r_prio;

            if (g == 0) begin : g_first
                assign w_l_le   = 1'b1;
                assign w_l_tag  = w_key_tag;
                assign w_l_prio = w_key_prio;
            end else begin : g_mid_l
                assign w_l_le   = w_le[g-1];
                assign w_l_tag  = w_tag[g-1];
                assign w_l_prio = w_prio[g-1];
            end

            if (g == QUEUE_DEPTH - 1) begin : g_last
                assign w_r_le   = 1'b0;
                assign w_r_tag  = w_tag[g];
                assign w_r_prio = w_prio[g];
            end else begin : g_mid_r
                assign w_r_le   = w_le[g+1];
                assign w_r_tag  = w_tag[g+1];
                assign w_r_prio = w_prio[g+1];
            end

            tapq_cell #(
                .TAG_WIDTH  (TAG_WIDTH),
                .PRIO_WIDTH (PRIO_WIDTH),
                .CNT_WIDTH  (CNT_WIDTH),
                .CELL_IDX   (g)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (w_ctrl),
                .i_key_tag    (w_key_tag),
                .i_key_prio   (w_key_prio),
                .i_count      (r_count),
                .i_left_le    (w_l_le),
                .i_left_tag   (w_l_tag),
                .i_left_prio  (w_l_prio),
                .i_right_le   (w_r_le),
                .i_right_tag  (w_r_tag),
                .i_right_prio (w_r_prio),
                .o_le         (w_le[g]),
                .o_tag        (w_tag[g]),
                .o_prio       (w_prio[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_running <= MAX_RUNNING_RST;
            r_queue_limit <= QUEUE_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MAX_RUNNING: r_max_running <= i_cfg_data;
                REG_QUEUE_LIMIT: r_queue_limit <= i_cfg_data[LIMIT_WIDTH-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_running   <= n_running;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status       <= n_status;
            r_launch_valid <= n_launch_valid;
            r_launch_tag   <= n_launch_tag;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_launch_valid  = r_launch_valid;
    assign o_launch_tag    = r_launch_tag;
    assign o_running_count = r_running;
    assign o_queue_length  = r_count;

endmodule
